### rtl/core/ctag_pkg.sv
// ctag_pkg: shared types and constants for the cache tag lookup block
// used by ctag_ctrl, ctag_dpath and cache_tag_lookup_dm_fa
// no dependencies
package ctag_pkg;

   localparam int LINES_DEF      = 8;
   localparam int COUNT_BITS_DEF = 16;

   localparam int ADDR_W     = 16;
   localparam int BLOCK_W    = 6;
   localparam int OFFSET_W   = 2;
   localparam int LINE_OUT_W = 3;
   localparam int HITS_OUT_W = 16;
   localparam int BLOCKS     = 1 << BLOCK_W;

   localparam logic MODE_DIRECT = 1'b0;
   localparam logic MODE_ASSOC  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load;     // capture address, clear scan state
      logic err_rsp;  // load a range error result
      logic scan;     // examine one directory entry
      logic update;   // write back the chosen line, load the result
   } cmd_type;

   typedef struct packed {
      logic range_err;
      logic scan_done;
   } status_type;

endpackage

### rtl/core/cache_tag_lookup_dm_fa.sv
// cache_tag_lookup_dm_fa: cache tag directory with direct mapped and fully
// associative lookup. an item steps through load, directory scan (one directory entry read
// per cycle fully associative, a single read direct mapped), update and result; a range
// error goes straight from load to the result. next item can be taken the cycle after the
// strobe. results cannot be stalled.
// reset (synchronous) invalidates all lines and selects direct mapped mode.
module cache_tag_lookup_dm_fa #(
   parameter int LINES      = ctag_pkg::LINES_DEF,
   parameter int COUNT_BITS = ctag_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ctag_pkg::ADDR_W-1:0]       req_address,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic                              rsp_replaced,
   output logic [ctag_pkg::LINE_OUT_W-1:0]   rsp_line_used,
   output logic [ctag_pkg::HITS_OUT_W-1:0]   rsp_line_hits,
   output logic [ctag_pkg::BLOCK_W-1:0]      rsp_block_number,
   output logic [ctag_pkg::OFFSET_W-1:0]     rsp_byte_offset,
   output logic                              rsp_range_error,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_mapping_mode
);
   import ctag_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = !busy;

   ctag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   ctag_dpath #(
      .LINES      (LINES),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_address      (req_address),
      .csr_write        (csr_valid && csr_ready),
      .csr_mapping_mode (csr_mapping_mode),
      .rsp_hit          (rsp_hit),
      .rsp_replaced     (rsp_replaced),
      .rsp_line_used    (rsp_line_used),
      .rsp_line_hits    (rsp_line_hits),
      .rsp_block_number (rsp_block_number),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_range_error  (rsp_range_error)
   );

endmodule

### rtl/core/ctag_ctrl.sv
// ctag_ctrl: sequencing state machine for the cache tag lookup
// drives ctag_dpath through cmd_type, reads status_type; uses ctag_pkg
module ctag_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   output ctag_pkg::cmd_type     cmd,
   input  ctag_pkg::status_type  status
);
   import ctag_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (status.range_err) begin
                  cmd.err_rsp = 1'b1;
                  state_in    = ST_RESPOND;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_update_then_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid)
      else $error("directory update not followed by a result");

endmodule

### rtl/core/ctag_dpath.sv
// ctag_dpath: tag directory, scan registers and result registers
// stepped by ctag_ctrl through cmd_type; uses ctag_pkg
module ctag_dpath #(
   parameter int LINES      = ctag_pkg::LINES_DEF,
   parameter int COUNT_BITS = ctag_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ctag_pkg::cmd_type                    cmd,
   output ctag_pkg::status_type                 status,
   input  logic [ctag_pkg::ADDR_W-1:0]          req_address,
   input  logic                                 csr_write,
   input  logic                                 csr_mapping_mode,
   output logic                                 rsp_hit,
   output logic                                 rsp_replaced,
   output logic [ctag_pkg::LINE_OUT_W-1:0]      rsp_line_used,
   output logic [ctag_pkg::HITS_OUT_W-1:0]      rsp_line_hits,
   output logic [ctag_pkg::BLOCK_W-1:0]         rsp_block_number,
   output logic [ctag_pkg::OFFSET_W-1:0]        rsp_byte_offset,
   output logic                                 rsp_range_error
);
   import ctag_pkg::*;

   localparam int IDX_W = $clog2(LINES);

   // directory
   logic                  line_valid_ff [LINES];
   logic [BLOCK_W-1:0]    line_tag_ff   [LINES];
   logic [COUNT_BITS-1:0] line_count_ff [LINES];

   logic                  mode_ff;
   logic [BLOCK_W-1:0]    block_ff;
   logic [OFFSET_W-1:0]   offset_ff;
   logic [IDX_W-1:0]      scan_ff;
   logic                  hit_found_ff;
   logic [IDX_W-1:0]      hit_idx_ff;
   logic                  empty_found_ff;
   logic [IDX_W-1:0]      empty_idx_ff;
   logic [IDX_W-1:0]      low_idx_ff;
   logic [COUNT_BITS-1:0] low_cnt_ff;

   logic                  rsp_hit_ff;
   logic                  rsp_replaced_ff;
   logic [LINE_OUT_W-1:0] rsp_line_ff;
   logic [HITS_OUT_W-1:0] rsp_hits_ff;
   logic [BLOCK_W-1:0]    rsp_block_ff;
   logic [OFFSET_W-1:0]   rsp_offset_ff;
   logic                  rsp_err_ff;

   // constant split of the block number into direct mapped line and tag
   logic [IDX_W-1:0]      dm_line_tab [BLOCKS];
   logic [BLOCK_W-1:0]    dm_tag_tab  [BLOCKS];

   genvar g;
   generate
      for (g = 0; g < BLOCKS; g++) begin : g_dm_tab
         assign dm_line_tab[g] = IDX_W'(g % LINES);
         assign dm_tag_tab[g]  = BLOCK_W'(g / LINES);
      end
   endgenerate

   logic [IDX_W-1:0]            dm_line;
   logic [BLOCK_W-1:0]          tag_cmp;
   logic [IDX_W-1:0]            sel_idx;
   logic [IDX_W-1:0]            rd_idx;
   logic                        rd_valid;
   logic [BLOCK_W-1:0]          rd_tag;
   logic [COUNT_BITS-1:0]       rd_count;
   logic                        rd_match;
   logic [COUNT_BITS-1:0]       new_count;
   logic [IDX_W+LINE_OUT_W-1:0] line_ext;
   logic [COUNT_BITS+HITS_OUT_W-1:0] count_ext;

   assign dm_line = dm_line_tab[block_ff];
   assign tag_cmp = (mode_ff == MODE_ASSOC) ? block_ff : dm_tag_tab[block_ff];

   always_comb begin
      if (hit_found_ff) begin
         sel_idx = hit_idx_ff;
      end else if (mode_ff == MODE_DIRECT) begin
         sel_idx = dm_line;
      end else if (empty_found_ff) begin
         sel_idx = empty_idx_ff;
      end else begin
         sel_idx = low_idx_ff;
      end
   end

   // one directory read port, address chosen by the current step
   always_comb begin
      if (cmd.update) begin
         rd_idx = sel_idx;
      end else if (mode_ff == MODE_ASSOC) begin
         rd_idx = scan_ff;
      end else begin
         rd_idx = dm_line;
      end
   end

   assign rd_valid = line_valid_ff[rd_idx];
   assign rd_tag   = line_tag_ff[rd_idx];
   assign rd_count = line_count_ff[rd_idx];
   assign rd_match = rd_valid && (rd_tag == tag_cmp);

   always_comb begin
      if (!hit_found_ff) begin
         new_count = '0;
      end else if (rd_count == {COUNT_BITS{1'b1}}) begin
         new_count = rd_count;
      end else begin
         new_count = rd_count + COUNT_BITS'(1);
      end
   end

   assign line_ext  = (IDX_W+LINE_OUT_W)'(sel_idx);
   assign count_ext = (COUNT_BITS+HITS_OUT_W)'(new_count);

   assign status.range_err = |req_address[ADDR_W-1:BLOCK_W+OFFSET_W];
   assign status.scan_done = (mode_ff == MODE_DIRECT) || (scan_ff == IDX_W'(LINES-1));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DIRECT;
      end else if (csr_write) begin
         mode_ff <= csr_mapping_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINES; i++) begin
            line_valid_ff[i] <= 1'b0;
         end
      end else if (cmd.update) begin
         line_valid_ff[sel_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         line_count_ff[sel_idx] <= new_count;
         if (!hit_found_ff) begin
            line_tag_ff[sel_idx] <= tag_cmp;
         end
      end
   end

   // scan registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         block_ff       <= req_address[BLOCK_W+OFFSET_W-1:OFFSET_W];
         offset_ff      <= req_address[OFFSET_W-1:0];
         scan_ff        <= '0;
         hit_found_ff   <= 1'b0;
         empty_found_ff <= 1'b0;
      end else if (cmd.scan) begin
         scan_ff <= scan_ff + IDX_W'(1);
         if (rd_match && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= rd_idx;
         end
         if (!rd_valid && !empty_found_ff) begin
            empty_found_ff <= 1'b1;
            empty_idx_ff   <= rd_idx;
         end
         // lowest count so far, ties stay on the lower index
         if (scan_ff == '0) begin
            low_idx_ff <= rd_idx;
            low_cnt_ff <= rd_count;
         end else if (rd_valid && (rd_count < low_cnt_ff)) begin
            low_idx_ff <= rd_idx;
            low_cnt_ff <= rd_count;
         end
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.err_rsp) begin
         rsp_hit_ff      <= 1'b0;
         rsp_replaced_ff <= 1'b0;
         rsp_line_ff     <= '0;
         rsp_hits_ff     <= '0;
         rsp_block_ff    <= '0;
         rsp_offset_ff   <= '0;
         rsp_err_ff      <= 1'b1;
      end else if (cmd.update) begin
         rsp_hit_ff      <= hit_found_ff;
         rsp_replaced_ff <= !hit_found_ff;
         rsp_line_ff     <= line_ext[LINE_OUT_W-1:0];
         rsp_hits_ff     <= count_ext[HITS_OUT_W-1:0];
         rsp_block_ff    <= block_ff;
         rsp_offset_ff   <= offset_ff;
         rsp_err_ff      <= 1'b0;
      end
   end

   assign rsp_hit          = rsp_hit_ff;
   assign rsp_replaced     = rsp_replaced_ff;
   assign rsp_line_used    = rsp_line_ff;
   assign rsp_line_hits    = rsp_hits_ff;
   assign rsp_block_number = rsp_block_ff;
   assign rsp_byte_offset  = rsp_offset_ff;
   assign rsp_range_error  = rsp_err_ff;

   a_line_valid_after_update: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> line_valid_ff[$past(sel_idx)])
      else $error("updated line not marked valid");

endmodule

### tb/cache_tag_lookup_dm_fa_tb.sv
// cache_tag_lookup_dm_fa_tb: self-checking bench for the cache tag directory, with
// directed rows, a repeated hit run and random traffic in both mapping modes
// depends on ctag_pkg and cache_tag_lookup_dm_fa
module cache_tag_lookup_dm_fa_tb;
   import ctag_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NLINES      = LINES_DEF;
   localparam int NCOUNT_BITS = COUNT_BITS_DEF;
   localparam int ADDR_TOP    = 255;
   localparam int HAMMER_REPS = 40;
   localparam int DRAIN_WAIT  = NLINES + 4;
   localparam int QUIET_LIMIT = 4000;
   localparam int MAX_REPORTS = 100;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 216;
   localparam int POOL_SIZE   = 12;

   typedef struct packed {
      logic                  hit;
      logic                  replaced;
      logic [LINE_OUT_W-1:0] line;
      logic [HITS_OUT_W-1:0] hits;
      logic [BLOCK_W-1:0]    block;
      logic [OFFSET_W-1:0]   offset;
      logic                  range_err;
   } lookup_rsp_type;

   typedef enum logic {ROW_LOOKUP, ROW_MODE} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              mode;
      logic [ADDR_W-1:0] addr;
      int                reps;
      logic              pinned;
      lookup_rsp_type    rsp;
   } dir_row_type;

   localparam lookup_rsp_type NO_PIN  = '0;
   localparam lookup_rsp_type ERR_RSP = '{1'b0, 1'b0, 3'd0, 16'd0, 6'd0, 2'd0, 1'b1};

   localparam int DIR_ROWS = 24;
   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      '{ROW_LOOKUP, MODE_DIRECT, 16'h0000, 1, 1'b1,
        '{1'b0, 1'b1, 3'd0, 16'd0, 6'd0, 2'd0, 1'b0}},
      '{ROW_LOOKUP, MODE_DIRECT, 16'h0003, 1, 1'b1,
        '{1'b1, 1'b0, 3'd0, 16'd1, 6'd0, 2'd3, 1'b0}},
      '{ROW_LOOKUP, MODE_DIRECT, 16'h00FF, 1, 1'b1,
        '{1'b0, 1'b1, 3'd7, 16'd0, 6'd63, 2'd3, 1'b0}},
      '{ROW_LOOKUP, MODE_DIRECT, 16'h0100, 1, 1'b1, ERR_RSP},
      '{ROW_LOOKUP, MODE_DIRECT, 16'hFFFF, 1, 1'b1, ERR_RSP},
      '{ROW_LOOKUP, MODE_DIRECT, 16'h00E2, 1, 1'b1,
        '{1'b0, 1'b1, 3'd0, 16'd0, 6'd56, 2'd2, 1'b0}},
      '{ROW_LOOKUP, MODE_DIRECT, 16'h00FC, 1, 1'b1,
        '{1'b1, 1'b0, 3'd7, 16'd1, 6'd63, 2'd0, 1'b0}},
      '{ROW_LOOKUP, MODE_DIRECT, 16'h0001, 1, 1'b1,
        '{1'b0, 1'b1, 3'd0, 16'd0, 6'd0, 2'd1, 1'b0}},
      // hammer line 0 to build up its count
      '{ROW_LOOKUP, MODE_DIRECT, 16'h0000, HAMMER_REPS, 1'b0, NO_PIN},
      // switch without flush: old direct mapped tags read as block numbers
      '{ROW_MODE,   MODE_ASSOC,  16'h0000, 0, 1'b0, NO_PIN},
      '{ROW_LOOKUP, MODE_ASSOC,  16'h0000, 1, 1'b1,
        '{1'b1, 1'b0, 3'd0, HITS_OUT_W'(HAMMER_REPS + 1), 6'd0, 2'd0, 1'b0}},
      '{ROW_LOOKUP, MODE_ASSOC,  16'h001C, 1, 1'b0, NO_PIN},
      '{ROW_LOOKUP, MODE_ASSOC,  16'h0028, 1, 1'b0, NO_PIN},
      '{ROW_LOOKUP, MODE_ASSOC,  16'h002D, 1, 1'b0, NO_PIN},
      '{ROW_LOOKUP, MODE_ASSOC,  16'h0032, 1, 1'b0, NO_PIN},
      '{ROW_LOOKUP, MODE_ASSOC,  16'h0037, 1, 1'b0, NO_PIN},
      '{ROW_LOOKUP, MODE_ASSOC,  16'h0038, 1, 1'b0, NO_PIN},
      '{ROW_LOOKUP, MODE_ASSOC,  16'h003F, 1, 1'b0, NO_PIN},
      '{ROW_LOOKUP, MODE_ASSOC,  16'h0029, 1, 1'b0, NO_PIN},
      // directory full: least-hit victims, ties to the lowest line
      '{ROW_LOOKUP, MODE_ASSOC,  16'h0080, 1, 1'b0, NO_PIN},
      '{ROW_LOOKUP, MODE_ASSOC,  16'h0086, 1, 1'b0, NO_PIN},
      '{ROW_LOOKUP, MODE_ASSOC,  16'h1234, 1, 1'b1, ERR_RSP},
      '{ROW_MODE,   MODE_DIRECT, 16'h0000, 0, 1'b0, NO_PIN},
      '{ROW_LOOKUP, MODE_DIRECT, 16'h0043, 1, 1'b0, NO_PIN}
   };

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [ADDR_W-1:0]     req_address;
   logic                  rsp_valid;
   logic                  rsp_hit;
   logic                  rsp_replaced;
   logic [LINE_OUT_W-1:0] rsp_line_used;
   logic [HITS_OUT_W-1:0] rsp_line_hits;
   logic [BLOCK_W-1:0]    rsp_block_number;
   logic [OFFSET_W-1:0]   rsp_byte_offset;
   logic                  rsp_range_error;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_mapping_mode;

   // directory shadow
   logic                   dir_mode;
   logic                   dir_valid [NLINES];
   logic [BLOCK_W-1:0]     dir_tag   [NLINES];
   logic [NCOUNT_BITS-1:0] dir_count [NLINES];

   lookup_rsp_type    pending_q [$];
   lookup_rsp_type    pin_rsp;
   logic              pin_en;
   int                gap_pct;
   int                mismatches;
   int                quiet_cycles;
   logic [BLOCK_W-1:0] block_pool [POOL_SIZE];

   cache_tag_lookup_dm_fa u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_replaced     (rsp_replaced),
      .rsp_line_used    (rsp_line_used),
      .rsp_line_hits    (rsp_line_hits),
      .rsp_block_number (rsp_block_number),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_range_error  (rsp_range_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_mapping_mode (csr_mapping_mode)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // updates the shadow directory and returns the result of one lookup
   function automatic lookup_rsp_type lookup_and_update(logic [ADDR_W-1:0] addr);
      lookup_rsp_type     r;
      logic [BLOCK_W-1:0] blk;
      logic [BLOCK_W-1:0] tag;
      logic               hit;
      int                 idx;
      int                 low;
      int                 empty;
      r = '0;
      if (addr > ADDR_TOP) begin
         r.range_err = 1'b1;
         return r;
      end
      blk   = addr[OFFSET_W +: BLOCK_W];
      hit   = 1'b0;
      idx   = 0;
      low   = 0;
      empty = -1;
      if (dir_mode == MODE_DIRECT) begin
         idx = blk % NLINES;
         tag = BLOCK_W'(blk / NLINES);
         hit = dir_valid[idx] && dir_tag[idx] == tag;
      end else begin
         tag = blk;
         for (int i = 0; i < NLINES; i++) begin
            if (!hit && dir_valid[i] && dir_tag[i] == tag) begin
               hit = 1'b1;
               idx = i;
            end
         end
         if (!hit) begin
            for (int i = 0; i < NLINES; i++) begin
               if (!dir_valid[i]) begin
                  if (empty < 0) empty = i;
               end else if (dir_count[i] < dir_count[low]) begin
                  low = i;
               end
            end
            idx = (empty >= 0) ? empty : low;
         end
      end
      if (hit) begin
         if (dir_count[idx] != '1) dir_count[idx] = dir_count[idx] + 1'b1;
      end else begin
         dir_valid[idx] = 1'b1;
         dir_tag[idx]   = tag;
         dir_count[idx] = '0;
      end
      r.hit      = hit;
      r.replaced = ~hit;
      r.line     = LINE_OUT_W'(idx);
      r.hits     = HITS_OUT_W'(dir_count[idx]);
      r.block    = blk;
      r.offset   = addr[OFFSET_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         // keep the log short when something breaks early
         if (mismatches <= MAX_REPORTS)
            $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // monitor: shadow updates on every handshake, result compare, watchdog
   always @(posedge clock) begin
      lookup_rsp_type want;
      logic           moved;
      if (reset) begin
         dir_mode     = MODE_DIRECT;
         quiet_cycles = 0;
         for (int i = 0; i < NLINES; i++) begin
            dir_valid[i] = 1'b0;
            dir_tag[i]   = '0;
            dir_count[i] = '0;
         end
      end else begin
         moved = 1'b0;
         if (rsp_valid === 1'b1) begin
            moved = 1'b1;
            if (pending_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) $error("result with no item pending");
            end else begin
               want = pending_q.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("replaced", 32'(want.replaced), 32'(rsp_replaced));
               check_field("line_used", 32'(want.line), 32'(rsp_line_used));
               check_field("line_hits", 32'(want.hits), 32'(rsp_line_hits));
               check_field("block_number", 32'(want.block), 32'(rsp_block_number));
               check_field("byte_offset", 32'(want.offset), 32'(rsp_byte_offset));
               check_field("range_error", 32'(want.range_err), 32'(rsp_range_error));
            end
         end
         if (csr_valid && csr_ready === 1'b1) begin
            moved    = 1'b1;
            dir_mode = csr_mapping_mode;
         end
         if (start && busy === 1'b0) begin
            moved = 1'b1;
            want  = lookup_and_update(req_address);
            pending_q.push_back(pin_en ? pin_rsp : want);
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_lookup(input logic [ADDR_W-1:0] addr, input logic pinned,
                              input lookup_rsp_type rsp);
      while ($urandom_range(99) < gap_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start       = 1'b1;
      req_address = addr;
      pin_en      = pinned;
      pin_rsp     = rsp;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start  = 1'b0;
      pin_en = 1'b0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_mode(input logic mode);
      wait_drained();
      csr_valid        = 1'b1;
      csr_mapping_mode = mode;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // mostly a small working set of blocks so hits and evictions keep coming
   function automatic logic [ADDR_W-1:0] pick_address();
      int r;
      r = $urandom_range(99);
      if (r < 6) return ADDR_W'($urandom_range(65535, ADDR_TOP + 1));
      if (r < 20) return ADDR_W'($urandom_range(ADDR_TOP));
      return {8'h00, block_pool[$urandom_range(POOL_SIZE - 1)],
              OFFSET_W'($urandom_range(3))};
   endfunction

   initial begin
      int idle_mix [PHASES];
      reset            = 1'b1;
      start            = 1'b0;
      req_address      = '0;
      csr_valid        = 1'b0;
      csr_mapping_mode = MODE_DIRECT;
      pin_en           = 1'b0;
      pin_rsp          = '0;
      gap_pct          = 0;
      mismatches       = 0;
      idle_mix         = '{0, 63, 6, 63, 0, 6};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIR_TAB[i].kind == ROW_MODE) begin
            write_mode(DIR_TAB[i].mode);
         end else begin
            for (int n = 0; n < DIR_TAB[i].reps; n++)
               send_lookup(DIR_TAB[i].addr, DIR_TAB[i].pinned, DIR_TAB[i].rsp);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         write_mode(p[0] ? MODE_DIRECT : MODE_ASSOC);
         gap_pct = idle_mix[p];
         for (int b = 0; b < POOL_SIZE; b++) block_pool[b] = BLOCK_W'($urandom_range(63));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // stretches without gaps inside the idling phases too
            if (idle_mix[p] != 0 && n % 50 == 0)
               gap_pct = (gap_pct == 0) ? idle_mix[p] : 0;
            send_lookup(pick_address(), 1'b0, NO_PIN);
         end
      end

      wait_drained();
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### files.f
rtl/core/ctag_pkg.sv
rtl/core/ctag_ctrl.sv
rtl/core/ctag_dpath.sv
rtl/core/cache_tag_lookup_dm_fa.sv
tb/cache_tag_lookup_dm_fa_tb.sv
